// ===== src/lbct_pkg.sv =====
package lbct_pkg;

    localparam int DEF_ENTRIES = 8;

    localparam int BASE_W  = 16;
    localparam int IDX_W   = 21;
    localparam int LBA_W   = 22;
    localparam int TAG_W   = 32;
    localparam int STAMP_W = 32;
    localparam int ENTRY_W = 3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [TAG_W-1:0] INVALID_TAG = '1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

endpackage

// ===== src/lbct_ram.sv =====
module lbct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lru_block_cache_tags_top.sv =====
// Tag and LRU replacement engine of a fully associative block cache. Each
// input transaction carries a block index and a fill status; the block adds
// the configured base LBA, looks the address up, restamps the hit entry or
// replaces the least recently stamped one, and returns one result transaction
// with the hit flag, the entry number and the absolute LBA. Tags and stamps
// live in one entry RAM with a single registered read port, which is scanned
// one entry per cycle: a lookup that hits entry k stops the scan there, while a
// miss scans all ENTRIES entries before its write back of the victim. The
// result sits in an output register, so a new request is taken while the
// previous result still waits; a result that is still waiting holds the next
// write back until it is taken. Entries read as invalid after reset through
// a valid bit per entry; no clearing pass is needed. The base LBA may only be
// written while no lookup is in flight.
module lru_block_cache_tags_top #(
    parameter int ENTRIES = lbct_pkg::DEF_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write: base_lba.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lbct_pkg::BASE_W-1:0]      i_cfg_data,
    // Request stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [20:0] block_index, [23:21] zero.
    input  logic [lbct_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: [0] fill_ok.
    input  logic                             s_axis_tuser,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [2:0] entry_index, [24:3] fetch_lba, [31:25] zero.
    output logic [lbct_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: [0] hit.
    output logic                             m_axis_tuser
);

    import lbct_pkg::*;

    localparam int IW     = $clog2(ENTRIES);
    localparam int WORD_W = STAMP_W + TAG_W;

    t_state               r_state;
    logic [BASE_W-1:0]    r_base;
    logic [LBA_W-1:0]     r_lba;
    logic                 r_fill_ok;
    logic [STAMP_W-1:0]   r_stamp_cnt;
    logic [ENTRIES-1:0]   r_vld;

    logic                 r_issuing;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_chk_vld;
    logic [IW-1:0]        r_chk_idx;
    logic [STAMP_W-1:0]   r_min_stamp;
    logic [IW-1:0]        r_vic;
    logic [IW-1:0]        r_sel;
    logic                 r_hit;

    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                 r_out_hit;

    logic [WORD_W-1:0]    rd_data;
    logic [TAG_W-1:0]     chk_tag;
    logic [STAMP_W-1:0]   chk_stamp;
    logic                 tag_match;
    logic                 take_min;
    logic [IW-1:0]        n_vic;
    logic [STAMP_W-1:0]   n_stamp_cnt;
    logic [TAG_W-1:0]     n_tag;
    logic                 out_free;
    logic                 write_go;
    logic                 in_accept;
    logic                 checking;
    logic                 chk_last;
    logic [IW-1:0]        ram_addr_r;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign out_free = !r_out_valid || m_axis_tready;
    assign write_go = (r_state == S_WRITE) && out_free;

    assign checking = (r_state == S_SCAN) && r_chk_vld;
    assign chk_last = (r_chk_idx == IW'(ENTRIES - 1));

    // An entry never written since reset reads as invalid tag with stamp zero.
    assign chk_tag   = r_vld[r_chk_idx] ? rd_data[TAG_W-1:0] : INVALID_TAG;
    assign chk_stamp = r_vld[r_chk_idx] ? rd_data[WORD_W-1:TAG_W] : '0;
    assign tag_match = (chk_tag == TAG_W'(r_lba));
    assign take_min  = (r_chk_idx == '0) || (chk_stamp < r_min_stamp);
    assign n_vic     = take_min ? r_chk_idx : r_vic;

    assign n_stamp_cnt = r_stamp_cnt + STAMP_W'(1);
    // On a hit the stored tag already equals the LBA.
    assign n_tag       = (r_hit || r_fill_ok) ? TAG_W'(r_lba) : INVALID_TAG;

    assign ram_addr_r = r_rd_idx;

    lbct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (write_go),
        .i_waddr (r_sel),
        .i_wdata ({n_stamp_cnt, n_tag}),
        .i_raddr (ram_addr_r),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_stamp_cnt <= '0;
            r_vld       <= '0;
            r_issuing   <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state   <= S_SCAN;
                        r_issuing <= 1'b1;
                        r_chk_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_chk_vld <= r_issuing;
                    if (r_issuing && (r_rd_idx == IW'(ENTRIES - 1))) begin
                        r_issuing <= 1'b0;
                    end
                    if (checking && (tag_match || chk_last)) begin
                        r_state   <= S_WRITE;
                        r_issuing <= 1'b0;
                        r_chk_vld <= 1'b0;
                    end
                end
                S_WRITE: begin
                    if (write_go) begin
                        r_state       <= S_IDLE;
                        r_stamp_cnt   <= n_stamp_cnt;
                        r_vld[r_sel]  <= 1'b1;
                        r_out_valid   <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, qualified by the control state above.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_lba     <= LBA_W'(r_base) + LBA_W'(s_axis_tdata[IDX_W-1:0]);
            r_fill_ok <= s_axis_tuser;
            r_rd_idx  <= '0;
        end else if ((r_state == S_SCAN) && r_issuing) begin
            r_rd_idx <= r_rd_idx + IW'(1);
        end

        if ((r_state == S_SCAN) && r_issuing) begin
            r_chk_idx <= r_rd_idx;
        end

        if (checking) begin
            if (tag_match) begin
                r_hit <= 1'b1;
                r_sel <= r_chk_idx;
            end else begin
                r_min_stamp <= take_min ? chk_stamp : r_min_stamp;
                r_vic       <= n_vic;
                r_hit       <= 1'b0;
                r_sel       <= n_vic;
            end
        end

        if (write_go) begin
            r_out_hit  <= r_hit;
            r_out_data <= {{(OUT_DATA_W - LBA_W - ENTRY_W){1'b0}}, r_lba, ENTRY_W'(r_sel)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

    a_stamp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        write_go |=> (r_stamp_cnt == $past(n_stamp_cnt)))
        else $error("stamp counter did not advance on write back");

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(write_go))
        else $error("result appeared without a write back");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (int'(r_sel) < ENTRIES))
        else $error("selected entry out of range");

    a_no_issue_outside_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_issuing)
        else $error("entry read issued while idle");

endmodule
